// ----- rtl/tlsm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the tagged latency stats monitor.
package tlsm_pkg;

    localparam int TAG_W    = 12;
    localparam int TIME_W   = 64;
    localparam int BIN_W_IN = 4;
    localparam int LIMIT_W  = 40;
    localparam int STAT_W   = 64;
    localparam int ADDR_W   = 4;
    localparam int CFG_W    = 64;
    localparam int STS_W    = 3;
    localparam int IN_W     = TAG_W + TIME_W + BIN_W_IN;
    localparam int OUT_W    = 5 * STAT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 40'd1000000000;

    typedef enum logic [1:0] {
        REQ_START    = 2'd0,
        REQ_COMPLETE = 2'd1,
        REQ_READ     = 2'd2,
        REQ_NONE     = 2'd3
    } req_t;

    localparam logic [STS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STS_W-1:0] ST_NO_RECORD    = 3'd1;
    localparam logic [STS_W-1:0] ST_NON_POSITIVE = 3'd2;
    localparam logic [STS_W-1:0] ST_OVER_LIMIT   = 3'd3;
    localparam logic [STS_W-1:0] ST_BAD_BIN      = 3'd4;

    typedef struct packed {
        logic capture;
        logic clr_step;
        logic start_wr;
        logic read_ld;
        logic fetch;
        logic check;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
    } sts_t;

endpackage

// ----- rtl/tlsm_regs.sv -----
`timescale 1ns / 1ps
// APB configuration register block (latency limit).
module tlsm_regs
    import tlsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [CFG_W-1:0]   pwdata,
    output logic [CFG_W-1:0]   prdata,
    output logic               pready,
    output logic [LIMIT_W-1:0] limit
);

    logic [LIMIT_W-1:0] limit_reg;
    logic               hit;

    assign pready = 1'b1;
    assign hit    = (paddr[ADDR_W-1] == 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && hit)
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = hit ? CFG_W'(limit_reg) : '0;
    assign limit  = limit_reg;

endmodule

// ----- rtl/tlsm_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for table clear, lookup, check and bin update.
module tlsm_ctrl
    import tlsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [1:0] s_axis_tuser,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output cmd_t       cmd,
    input  sts_t       sts
);

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        LOOKUP,
        CHECK,
        UPDATE
    } state_t;

    state_t state_reg, state_next;
    req_t   req_reg, req_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   load;

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == IDLE);
    assign m_axis_tvalid = m_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == IDLE) && s_axis_tvalid;
        cmd.clr_step = (state_reg == CLEAR);
        cmd.start_wr = (state_reg == LOOKUP) && (req_reg == REQ_START) && out_free;
        cmd.read_ld  = (state_reg == LOOKUP) && (req_reg == REQ_READ) && out_free;
        cmd.fetch    = (state_reg == LOOKUP) && (req_reg == REQ_COMPLETE);
        cmd.check    = (state_reg == CHECK);
        cmd.update   = (state_reg == UPDATE) && out_free;
    end

    assign load = cmd.start_wr || cmd.read_ld || cmd.update;

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        m_valid_next = m_valid_reg;
        if (load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = IDLE;
                end
            end
            IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next = req_t'(s_axis_tuser);
                    if (req_t'(s_axis_tuser) != REQ_NONE)
                    begin
                        state_next = LOOKUP;
                    end
                end
            end
            LOOKUP:
            begin
                if (req_reg == REQ_COMPLETE)
                begin
                    state_next = CHECK;
                end
                else if (out_free)
                begin
                    state_next = IDLE;
                end
            end
            CHECK:
            begin
                state_next = UPDATE;
            end
            UPDATE:
            begin
                if (out_free)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= CLEAR;
            req_reg     <= REQ_NONE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            req_reg     <= req_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- rtl/tlsm_dp.sv -----
`timescale 1ns / 1ps
// Datapath: tag timestamp table, elapsed time check, per-bin statistics, result register.
module tlsm_dp
    import tlsm_pkg::*;
#(
    parameter int TAG_SLOTS = 4096,
    parameter int BIN_COUNT = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [TAG_W-1:0]    tag,
    input  logic [TIME_W-1:0]   now_time,
    input  logic [BIN_W_IN-1:0] bin_index,
    input  logic [LIMIT_W-1:0]  limit,
    output logic [STS_W-1:0]    res_status,
    output logic [OUT_W-1:0]    res_data
);

    localparam int SLOT_W      = $clog2(TAG_SLOTS);
    localparam int BIN_W       = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int RECIP_SHIFT = 24;
    localparam logic [24:0] RECIP = 25'((1 << RECIP_SHIFT) / TAG_SLOTS + 1);
    localparam logic [16:0] SLOTS_K   = 17'(TAG_SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TAG_SLOTS - 1);
    localparam logic [BIN_W_IN:0] BINS_K = (BIN_W_IN + 1)'(BIN_COUNT);

    logic [TAG_W-1:0]    tag_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [BIN_W_IN-1:0] bin_reg;
    logic [TAG_W-1:0]    quo_reg;
    logic [36:0]         quo_prod;
    logic [28:0]         wrap_prod;
    logic [TAG_W-1:0]    slot_rem;
    logic [SLOT_W-1:0]   slot;
    logic [SLOT_W-1:0]   clr_cnt_reg;

    logic [TIME_W:0]     tag_mem [TAG_SLOTS];
    logic [TIME_W:0]     rd_reg;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_wa;
    logic [TIME_W:0]     mem_wd;

    logic [TIME_W:0]     diff;
    logic                non_pos;
    logic [TIME_W-1:0]   elapsed_reg;
    logic [STS_W-1:0]    pre_err_reg;

    logic [STAT_W-1:0]   stat_cnt_reg [BIN_COUNT];
    logic [STAT_W-1:0]   stat_tot_reg [BIN_COUNT];
    logic [STAT_W-1:0]   stat_min_reg [BIN_COUNT];
    logic [STAT_W-1:0]   stat_max_reg [BIN_COUNT];
    logic [BIN_W-1:0]    bin_idx;
    logic                bin_ok;
    logic                over;
    logic [STS_W-1:0]    upd_status;
    logic [STAT_W-1:0]   cur_cnt, cur_tot, cur_min, cur_max;
    logic [STAT_W-1:0]   new_cnt, new_tot, new_min, new_max;

    logic [STS_W-1:0]    res_status_reg;
    logic [OUT_W-1:0]    res_data_reg;

    // tag modulo TAG_SLOTS: reciprocal quotient at capture, remainder in lookup
    assign quo_prod = 37'(tag) * 37'(RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tag_reg <= tag;
            now_reg <= now_time;
            bin_reg <= bin_index;
            quo_reg <= quo_prod[RECIP_SHIFT +: TAG_W];
        end
    end

    assign wrap_prod = 29'(quo_reg) * 29'(SLOTS_K);
    assign slot_rem  = tag_reg - wrap_prod[TAG_W-1:0];
    assign slot      = SLOT_W'(slot_rem);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign sts.clr_last = (clr_cnt_reg == SLOT_LAST);

    // entry = {valid, start stamp}
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = slot;
        mem_wd = '0;
        if (cmd.clr_step)
        begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_reg;
        end
        else if (cmd.start_wr)
        begin
            mem_we = 1'b1;
            mem_wd = {1'b1, now_reg};
        end
        else if (cmd.check)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[mem_wa] <= mem_wd;
        end
        if (cmd.fetch)
        begin
            rd_reg <= tag_mem[slot];
        end
    end

    assign diff    = {1'b0, now_reg} - {1'b0, rd_reg[TIME_W-1:0]};
    assign non_pos = diff[TIME_W] || (diff[TIME_W-1:0] == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            elapsed_reg <= diff[TIME_W-1:0];
            if (!rd_reg[TIME_W])
            begin
                pre_err_reg <= ST_NO_RECORD;
            end
            else if (non_pos)
            begin
                pre_err_reg <= ST_NON_POSITIVE;
            end
            else
            begin
                pre_err_reg <= ST_OK;
            end
        end
    end

    assign bin_idx = bin_reg[BIN_W-1:0];
    assign bin_ok  = ({1'b0, bin_reg} < BINS_K);
    assign over    = (elapsed_reg > TIME_W'(limit));

    always_comb
    begin
        if (pre_err_reg != ST_OK)
        begin
            upd_status = pre_err_reg;
        end
        else if (over)
        begin
            upd_status = ST_OVER_LIMIT;
        end
        else if (!bin_ok)
        begin
            upd_status = ST_BAD_BIN;
        end
        else
        begin
            upd_status = ST_OK;
        end
    end

    always_comb
    begin
        cur_cnt = '0;
        cur_tot = '0;
        cur_min = '0;
        cur_max = '0;
        if (bin_ok)
        begin
            cur_cnt = stat_cnt_reg[bin_idx];
            cur_tot = stat_tot_reg[bin_idx];
            cur_min = stat_min_reg[bin_idx];
            cur_max = stat_max_reg[bin_idx];
        end
    end

    assign new_cnt = cur_cnt + 1'b1;
    assign new_tot = cur_tot + elapsed_reg;
    assign new_min = ((cur_min == '0) || (elapsed_reg < cur_min)) ? elapsed_reg : cur_min;
    assign new_max = (elapsed_reg > cur_max) ? elapsed_reg : cur_max;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BIN_COUNT; i++)
            begin
                stat_cnt_reg[i] <= '0;
                stat_tot_reg[i] <= '0;
                stat_min_reg[i] <= '0;
                stat_max_reg[i] <= '0;
            end
        end
        else if (cmd.update && (upd_status == ST_OK))
        begin
            stat_cnt_reg[bin_idx] <= new_cnt;
            stat_tot_reg[bin_idx] <= new_tot;
            stat_min_reg[bin_idx] <= new_min;
            stat_max_reg[bin_idx] <= new_max;
        end
    end

    // result: {max, min, total, count, latency}
    always_ff @(posedge clk)
    begin
        if (cmd.start_wr)
        begin
            res_status_reg <= ST_OK;
            res_data_reg   <= '0;
        end
        else if (cmd.read_ld)
        begin
            if (bin_ok)
            begin
                res_status_reg <= ST_OK;
                res_data_reg   <= {cur_max, cur_min, cur_tot, cur_cnt, {STAT_W{1'b0}}};
            end
            else
            begin
                res_status_reg <= ST_BAD_BIN;
                res_data_reg   <= '0;
            end
        end
        else if (cmd.update)
        begin
            res_status_reg <= upd_status;
            if (upd_status == ST_OK)
            begin
                res_data_reg <= {new_max, new_min, new_tot, new_cnt, elapsed_reg};
            end
            else
            begin
                res_data_reg <= '0;
            end
        end
    end

    assign res_status = res_status_reg;
    assign res_data   = res_data_reg;

endmodule

// ----- rtl/tagged_latency_stats_monitor_core.sv -----
`timescale 1ns / 1ps
// Top level of the tagged latency stats monitor.
// Start, complete and read requests come in one at a time; each gives exactly one result
// transfer (request type 3 is dropped without a result). After reset the tag table is
// cleared one slot per cycle through all TAG_SLOTS slots, with s_axis_tready low; the limit
// register can be written during that time. A start or read is accepted in IDLE and loads
// the result register in LOOKUP once the output is free. A complete goes from IDLE through
// LOOKUP (slot lookup with registered table read), CHECK (elapsed check) and UPDATE (bin
// update), where it loads the result once the output is free; these steps are set by the
// single-port tag table and the read-modify-write of the bin. A type 3 request leaves the
// sequencer in IDLE. The next request is taken while a result still waits on m_axis_tready;
// a new result is held back until the previous one has gone out, which stretches that item.
module tagged_latency_stats_monitor_core
    import tlsm_pkg::*;
#(
    parameter int TAG_SLOTS = 4096,
    parameter int BIN_COUNT = 11
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,   // tag[11:0], now_time[75:12], bin_index[79:76]
    input  logic [1:0]        s_axis_tuser,   // req_type[1:0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // latency, bin_count, bin_total, bin_min, bin_max
    output logic [STS_W-1:0]  m_axis_tuser,   // status[2:0]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    cmd_t               cmd;
    sts_t               sts;
    logic [LIMIT_W-1:0] limit;

    tlsm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limit   (limit)
    );

    tlsm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd),
        .sts           (sts)
    );

    tlsm_dp #(
        .TAG_SLOTS (TAG_SLOTS),
        .BIN_COUNT (BIN_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .tag        (s_axis_tdata[TAG_W-1:0]),
        .now_time   (s_axis_tdata[TAG_W +: TIME_W]),
        .bin_index  (s_axis_tdata[TAG_W + TIME_W +: BIN_W_IN]),
        .limit      (limit),
        .res_status (m_axis_tuser),
        .res_data   (m_axis_tdata)
    );

endmodule

// ----- rtl/tlsm_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the tagged latency stats monitor, bound to the top level.
module tlsm_checker
    import tlsm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [1:0]        s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_W-1:0]  m_axis_tdata,
    input logic [STS_W-1:0]  m_axis_tuser
);

    logic [STAT_W-1:0] lat, cnt, mn, mx;

    assign lat = m_axis_tdata[0 +: STAT_W];
    assign cnt = m_axis_tdata[STAT_W +: STAT_W];
    assign mn  = m_axis_tdata[3*STAT_W +: STAT_W];
    assign mx  = m_axis_tdata[4*STAT_W +: STAT_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ST_BAD_BIN))
        else $error("status code out of range");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("error result carries data");

    a_lat_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_OK) && (lat != '0) |->
            (cnt != '0) && (mn != '0) && (mn <= lat) && (lat <= mx))
        else $error("latency outside bin min/max");

    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != REQ_NONE) |=> !s_axis_tready)
        else $error("new request taken while busy");

endmodule

bind tagged_latency_stats_monitor_core tlsm_checker u_tlsm_checker (.*);
